// ===== src/vlct_pkg.sv =====
package vlct_pkg;

  localparam int unsigned LineW  = 9;
  localparam int unsigned FieldW = 7;
  localparam int unsigned TimeW  = 16;

  localparam logic [LineW-1:0]  MaxLines     = LineW'(500);
  localparam logic [FieldW-1:0] FieldWrap    = FieldW'(100);
  localparam logic [FieldW-1:0] FieldBlinkOn = FieldW'(50);

  // Event codes carried in the input tuser field.
  localparam logic [1:0] EvLineSync  = 2'd0;
  localparam logic [1:0] EvFieldSync = 2'd1;
  localparam logic [1:0] EvOverflow  = 2'd2;

  // Crop modes.
  localparam logic [1:0] ModeNone     = 2'd0;
  localparam logic [1:0] ModeArtifact = 2'd1;
  localparam logic [1:0] ModeSymm     = 2'd2;
  localparam logic [1:0] ModeBorders  = 2'd3;

  typedef struct packed {
    logic [LineW-1:0] field_lo;
    logic [LineW-1:0] field_hi;
    logic [LineW-1:0] screen_lo;
    logic [LineW-1:0] screen_hi;
    logic [TimeW-1:0] start;
    logic [TimeW-1:0] border_len;
    logic [TimeW-1:0] screen_len;
    logic [TimeW-1:0] alt_len;
  } crop_row_t;

  function automatic crop_row_t crop_row(input logic [1:0] mode);
    crop_row_t r;
    r = '0;
    case (mode)
      ModeArtifact: r = '{9'd7, 9'd307, 9'd0,  9'd400, 16'd99, 16'd1055, 16'd12, 16'd0};
      ModeSymm:     r = '{9'd7, 9'd307, 9'd0,  9'd400, 16'd99, 16'd1055, 16'd35, 16'd0};
      ModeBorders:  r = '{9'd7, 9'd307, 9'd25, 9'd293, 16'd99, 16'd1055, 16'd35, 16'd0};
      default:      r = '0;
    endcase
    return r;
  endfunction

  // Window prepared for the following line.
  typedef struct packed {
    logic             apply;
    logic [TimeW-1:0] start;
    logic [TimeW-1:0] length;
  } window_t;

  typedef struct packed {
    logic             window_valid;
    logic [TimeW-1:0] switch_on_time;
    logic [TimeW-1:0] switch_off_time;
    logic             compare_enable;
    logic             signal_led;
    logic             blink_led;
  } result_t;

endpackage

// ===== src/video_line_crop_timer_top.sv =====
// Channel   Direction  Handshake                 Payload
// s_axis    in         s_axis_tvalid/tready      tuser: event_kind; tdata: capture_time
// m_axis    out        m_axis_tvalid/tready      tuser: window_valid; tdata: times and lamps
// cfg       in         cfg_we_i (no wait)        cfg_wdata_i: crop_mode
//
// Each item passes an input register and then a result register before its result
// appears on m_axis; one item is accepted every cycle while m_axis_tready
// is high. The state update and crop-window lookup are one short combinational step
// taken as an item moves from the input register into the result register.
// Reset clears all counters, lamps, the prepared window and the crop mode.
// A stall on the output holds the result register and backs up into the input register.
module video_line_crop_timer_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_wdata_i,   // crop_mode
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // [15:0] capture_time
  input  logic [1:0]  s_axis_tuser,  // [1:0] event_kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [15:0] switch_on_time, [31:16] switch_off_time, [32] compare_enable,
  // [33] signal_led, [34] blink_led, [39:35] zero
  output logic [39:0] m_axis_tdata,
  output logic        m_axis_tuser   // [0] window_valid
);
  import vlct_pkg::*;

  logic [1:0]       mode_q;
  logic             in_valid_q;
  logic [1:0]       in_kind_q;
  logic [TimeW-1:0] in_cap_q;
  logic             out_valid_q;
  result_t          out_q;
  result_t          res;
  logic             advance;

  // The input register moves forward whenever the result register is empty or
  // is being drained in the same cycle.
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  vlct_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .mode_i (mode_q),
    .step_i (advance),
    .kind_i (in_kind_q),
    .cap_i  (in_cap_q),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeNone;
    end else if (cfg_we_i) begin
      mode_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_kind_q <= s_axis_tuser;
      in_cap_q  <= s_axis_tdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.window_valid;
  assign m_axis_tdata  = {5'b0, out_q.blink_led, out_q.signal_led, out_q.compare_enable,
                          out_q.switch_off_time, out_q.switch_on_time};

endmodule

// ===== src/vlct_window.sv =====
module vlct_window (
  input  logic [1:0]                 mode_i,
  input  logic [vlct_pkg::LineW-1:0] line_i,
  output vlct_pkg::window_t          win_o
);
  import vlct_pkg::*;

  crop_row_t row;
  logic      in_field;
  logic      in_screen;

  always_comb begin
    row       = crop_row(mode_i);
    in_field  = (line_i >= row.field_lo) && (line_i <= row.field_hi);
    in_screen = (line_i >= row.screen_lo) && (line_i <= row.screen_hi);

    win_o.apply = in_field && (row.start != '0);
    win_o.start = row.start;
    if (!in_screen) begin
      win_o.length = row.border_len;
    end else if (!line_i[0]) begin
      win_o.length = row.screen_len + row.alt_len;
    end else begin
      win_o.length = row.screen_len;
    end
  end

endmodule

// ===== src/vlct_core.sv =====
module vlct_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [1:0]                 mode_i,
  input  logic                       step_i,
  input  logic [1:0]                 kind_i,
  input  logic [vlct_pkg::TimeW-1:0] cap_i,
  output vlct_pkg::result_t          res_o
);
  import vlct_pkg::*;

  logic [LineW-1:0]  line_q, line_d;
  logic [FieldW-1:0] field_q, field_d, field_inc;
  logic              in_fs_q, in_fs_d;
  logic [TimeW-1:0]  start_q, start_d;
  logic [TimeW-1:0]  len_q, len_d;
  logic              cmp_q, cmp_d;
  logic              sig_q, sig_d;
  logic              blink_q, blink_d;
  logic [LineW-1:0]  win_line;
  logic [TimeW-1:0]  on_time;
  window_t           win;

  // A line sync prepares the window for the line it starts; a field sync
  // prepares it for line zero.
  assign win_line = (kind_i == EvLineSync) ? (line_q + LineW'(1)) : '0;

  vlct_window u_window (
    .mode_i (mode_i),
    .line_i (win_line),
    .win_o  (win)
  );

  always_comb begin
    line_d    = line_q;
    field_d   = field_q;
    in_fs_d   = in_fs_q;
    start_d   = start_q;
    len_d     = len_q;
    cmp_d     = cmp_q;
    sig_d     = sig_q;
    blink_d   = blink_q;
    field_inc = field_q + FieldW'(1);
    on_time   = cap_i + start_q;

    res_o.window_valid    = 1'b0;
    res_o.switch_on_time  = '0;
    res_o.switch_off_time = '0;

    case (kind_i)
      EvLineSync: begin
        if (start_q != '0) begin
          res_o.window_valid    = 1'b1;
          res_o.switch_on_time  = on_time;
          res_o.switch_off_time = on_time + len_q;
        end
        if (line_q < MaxLines) begin
          line_d = line_q + LineW'(1);
          if (win.apply) begin
            start_d = win.start;
            len_d   = win.length;
          end else begin
            start_d = '0;
          end
        end else begin
          start_d = '0;
        end
        in_fs_d = 1'b0;
      end
      EvFieldSync: begin
        if (!in_fs_q) begin
          in_fs_d = 1'b1;
          line_d  = '0;
          if (field_inc == FieldWrap) begin
            field_d = '0;
            blink_d = 1'b0;
          end else begin
            field_d = field_inc;
            if (field_inc == FieldBlinkOn) begin
              blink_d = 1'b1;
            end
          end
          if (win.apply) begin
            start_d = win.start;
            len_d   = win.length;
          end else begin
            start_d = '0;
          end
          cmp_d = 1'b1;
          sig_d = 1'b0;
        end
      end
      EvOverflow: begin
        cmp_d   = 1'b0;
        sig_d   = 1'b1;
        blink_d = 1'b0;
      end
      default: begin
      end
    endcase

    res_o.compare_enable = cmp_d;
    res_o.signal_led     = sig_d;
    res_o.blink_led      = blink_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_q  <= '0;
      field_q <= '0;
      in_fs_q <= 1'b0;
      start_q <= '0;
      len_q   <= '0;
      cmp_q   <= 1'b0;
      sig_q   <= 1'b0;
      blink_q <= 1'b0;
    end else if (step_i) begin
      line_q  <= line_d;
      field_q <= field_d;
      in_fs_q <= in_fs_d;
      start_q <= start_d;
      len_q   <= len_d;
      cmp_q   <= cmp_d;
      sig_q   <= sig_d;
      blink_q <= blink_d;
    end
  end

endmodule

// ===== dv/video_line_crop_timer_top_tb.sv =====
module video_line_crop_timer_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import vlct_pkg::*;

  // The event code that the block must ignore. It changes no state, and the lamps
  // and compare flag come back unchanged.
  localparam logic [1:0] EvUnused = 2'd3;

  // Crop geometry, in lines and timer ticks.
  localparam logic [LineW-1:0] BandFirstLine   = 9'd7;
  localparam logic [LineW-1:0] BandLastLine    = 9'd307;
  localparam logic [LineW-1:0] ScreenTopNarrow = 9'd25;
  localparam logic [LineW-1:0] ScreenBotNarrow = 9'd293;
  localparam logic [LineW-1:0] ScreenBotWide   = 9'd400;
  localparam logic [TimeW-1:0] CropStartTicks  = 16'd99;
  localparam logic [TimeW-1:0] BorderTicks     = 16'd1055;
  localparam logic [TimeW-1:0] ArtifactTicks   = 16'd12;
  localparam logic [TimeW-1:0] SymmetricTicks  = 16'd35;

  localparam int unsigned QuietLimit   = 1000;
  localparam int unsigned ReportLimit  = 10;
  localparam int unsigned RandomEvents = 400;

  logic        clk_i;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic [1:0]  cfg_wdata_i   = ModeNone;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata  = '0;
  logic [1:0]  s_axis_tuser  = EvLineSync;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic        m_axis_tuser;

  video_line_crop_timer_top DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // Shadow of the sync tracker. It is advanced once for every item the block
  // accepts, so the queue below always holds results in acceptance order.
  logic [1:0]       crop_sel        = ModeNone;
  logic [LineW-1:0] line_count      = '0;
  logic [FieldW-1:0] field_count    = '0;
  logic             field_sync_seen = 1'b0;
  logic [TimeW-1:0] win_start       = '0;
  logic [TimeW-1:0] win_len         = '0;
  logic             cmp_on          = 1'b0;
  logic             no_signal_lamp  = 1'b0;
  logic             blink_lamp      = 1'b0;

  result_t     expected_sync_results[$];
  int unsigned mismatches   = 0;
  int unsigned quiet_cycles = 0;

  // Chance in percent that the sender inserts a gap before an item, and that
  // the receiver holds tready low in a cycle.
  int unsigned send_gap_pct   = 15;
  int unsigned recv_stall_pct = 66;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Sets up the window that the next line sync will use. Outside the field band,
  // or with cropping off, only the start is cleared; the length keeps its old value.
  task automatic arm_window(input logic [LineW-1:0] line);
    logic [LineW-1:0] top;
    logic [LineW-1:0] bottom;
    logic [TimeW-1:0] screen_ticks;
    top          = (crop_sel == ModeBorders) ? ScreenTopNarrow : '0;
    bottom       = (crop_sel == ModeBorders) ? ScreenBotNarrow : ScreenBotWide;
    screen_ticks = (crop_sel == ModeArtifact) ? ArtifactTicks : SymmetricTicks;
    if (crop_sel == ModeNone || line < BandFirstLine || line > BandLastLine) begin
      win_start = '0;
    end else begin
      win_start = CropStartTicks;
      win_len   = (line < top || line > bottom) ? BorderTicks : screen_ticks;
    end
  endtask

  task automatic predict_sync_event(input logic [1:0] kind, input logic [15:0] capture,
                                    output result_t r);
    r = '0;
    case (kind)
      EvLineSync: begin
        if (win_start != '0) begin
          r.window_valid    = 1'b1;
          r.switch_on_time  = capture + win_start;
          r.switch_off_time = r.switch_on_time + win_len;
        end
        // The line count freezes at its limit and the following lines go uncropped.
        if (line_count < MaxLines) begin
          line_count = line_count + 1'b1;
          arm_window(line_count);
        end else begin
          win_start = '0;
        end
        field_sync_seen = 1'b0;
      end
      EvFieldSync: begin
        // Only the first long pulse after a line sync starts a new field.
        if (!field_sync_seen) begin
          field_sync_seen = 1'b1;
          line_count      = '0;
          field_count     = field_count + 1'b1;
          if (field_count == FieldWrap) begin
            field_count = '0;
            blink_lamp  = 1'b0;
          end else if (field_count == FieldBlinkOn) begin
            blink_lamp = 1'b1;
          end
          arm_window(line_count);
          cmp_on         = 1'b1;
          no_signal_lamp = 1'b0;
        end
      end
      EvOverflow: begin
        cmp_on         = 1'b0;
        no_signal_lamp = 1'b1;
        blink_lamp     = 1'b0;
      end
      default: begin
      end
    endcase
    r.compare_enable = cmp_on;
    r.signal_led     = no_signal_lamp;
    r.blink_led      = blink_lamp;
  endtask

  // Offers one item, with random gaps in front of it, and records its expected
  // result once the block has taken it.
  task automatic send_sync_event(input logic [1:0] kind, input logic [15:0] capture);
    result_t r;
    while ($urandom_range(99) < send_gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= capture;
    do begin
      @(posedge clk_i);
    end while (!s_axis_tready);
    predict_sync_event(kind, capture, r);
    expected_sync_results.push_back(r);
  endtask

  // Every item yields exactly one result, so the block is idle once the queue
  // has emptied.
  task automatic wait_results_drained();
    s_axis_tvalid <= 1'b0;
    do begin
      @(posedge clk_i);
    end while (expected_sync_results.size() != 0);
  endtask

  task automatic set_crop_mode(input logic [1:0] mode);
    wait_results_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= mode;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    crop_sel  = mode;
  endtask

  // Extremes of the capture time, every event code, repeated field pulses, and
  // compare times that wrap past the top of the timer.
  task automatic test_directed_events();
    send_sync_event(EvLineSync, 16'h0000);
    send_sync_event(EvOverflow, 16'hFFFF);
    send_sync_event(EvUnused, 16'hFFFF);
    send_sync_event(EvFieldSync, 16'h0000);
    send_sync_event(EvFieldSync, 16'h5A5A);
    send_sync_event(EvLineSync, 16'hFFFF);
    set_crop_mode(ModeBorders);
    send_sync_event(EvFieldSync, 16'hA5A5);
    // The eighth line is the first one with a window; both times wrap around.
    repeat (8) send_sync_event(EvLineSync, 16'hFFFF);
    send_sync_event(EvLineSync, 16'hFF00);
    send_sync_event(EvLineSync, 16'h0000);
    // An overflow in mid-field clears the compare flag and the blink lamp and
    // lights the no-signal lamp, but leaves the window armed.
    send_sync_event(EvOverflow, 16'h1234);
    send_sync_event(EvLineSync, 16'h7FFF);
  endtask

  // Runs one field past the line limit, then checks that the next field sync
  // brings the count and the windows back.
  task automatic test_line_overrun();
    set_crop_mode(ModeSymm);
    send_sync_event(EvFieldSync, 16'($urandom));
    repeat (int'(MaxLines) + 5) send_sync_event(EvLineSync, 16'($urandom));
    send_sync_event(EvFieldSync, 16'($urandom));
    repeat (10) send_sync_event(EvLineSync, 16'($urandom));
  endtask

  // Enough short fields to pass the blink turn-on and the field count wrap.
  task automatic test_field_wrap();
    set_crop_mode(ModeArtifact);
    for (int i = 0; i < 105; i++) begin
      send_sync_event(EvFieldSync, 16'($urandom));
      if ($urandom_range(4) == 0) send_sync_event(EvFieldSync, 16'($urandom));
      if (i == 70) send_sync_event(EvOverflow, 16'($urandom));
      send_sync_event(EvLineSync, 16'($urandom));
    end
  endtask

  // Mostly well-formed fields of random length with random capture times, plus
  // a share of stray events. The three phases step through the idling patterns.
  task automatic test_random_traffic();
    int unsigned sent;
    int unsigned lines;
    int unsigned roll;
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_gap_pct   = 15;
          recv_stall_pct = 66;
          set_crop_mode(ModeBorders);
        end
        1: begin
          send_gap_pct   = 66;
          recv_stall_pct = 15;
          set_crop_mode(2'($urandom_range(3, 1)));
        end
        default: begin
          send_gap_pct   = 0;
          recv_stall_pct = 0;
          set_crop_mode(2'($urandom_range(3)));
        end
      endcase
      sent = 0;
      while (sent < RandomEvents / 3) begin
        if ($urandom_range(99) < 85) begin
          send_sync_event(EvFieldSync, 16'($urandom));
          sent++;
          if ($urandom_range(9) == 0) send_sync_event(EvFieldSync, 16'($urandom));
          // Short fields dominate; now and then one runs deep into the bottom border.
          roll = $urandom_range(19);
          if (roll < 13)      lines = $urandom_range(30, 1);
          else if (roll < 19) lines = $urandom_range(60, 20);
          else                lines = $urandom_range(320, 290);
          repeat (lines) begin
            send_sync_event(EvLineSync, 16'($urandom));
            sent++;
            if ($urandom_range(39) == 0) begin
              send_sync_event(2'($urandom_range(3)), 16'($urandom));
            end
          end
        end else begin
          send_sync_event(2'($urandom_range(3)), 16'($urandom));
          sent++;
        end
      end
    end
  endtask

  function automatic string fmt_result(input result_t r);
    return $sformatf("valid=%0d on=%h off=%h cmp=%0d sig=%0d blink=%0d",
                     r.window_valid, r.switch_on_time, r.switch_off_time,
                     r.compare_enable, r.signal_led, r.blink_led);
  endfunction

  // Result side: random backpressure, and a field-wise compare of every result
  // the block hands over against the oldest expectation.
  always @(posedge clk_i) begin : check_results
    result_t seen;
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      seen.window_valid    = m_axis_tuser;
      seen.switch_on_time  = m_axis_tdata[15:0];
      seen.switch_off_time = m_axis_tdata[31:16];
      seen.compare_enable  = m_axis_tdata[32];
      seen.signal_led      = m_axis_tdata[33];
      seen.blink_led       = m_axis_tdata[34];
      if (expected_sync_results.size() == 0) begin
        mismatches++;
        if (mismatches <= ReportLimit) begin
          $display("%0t: result with nothing expected: %s", $realtime, fmt_result(seen));
        end
      end else begin
        want = expected_sync_results.pop_front();
        if (seen.window_valid !== want.window_valid ||
            seen.switch_on_time !== want.switch_on_time ||
            seen.switch_off_time !== want.switch_off_time ||
            seen.compare_enable !== want.compare_enable ||
            seen.signal_led !== want.signal_led ||
            seen.blink_led !== want.blink_led ||
            m_axis_tdata[39:35] !== '0) begin
          mismatches++;
          if (mismatches <= ReportLimit) begin
            $display("%0t: expected %s", $realtime, fmt_result(want));
            $display("%0t: got      %s pad=%b", $realtime, fmt_result(seen),
                     m_axis_tdata[39:35]);
          end
        end
      end
    end
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Ends a hung run: too many cycles in a row without an item moving on either side.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_events();
    test_line_overrun();
    test_field_wrap();
    test_random_traffic();
    wait_results_drained();
    // Give a stray result time to show after the queue has drained.
    repeat (4) @(posedge clk_i);
    if (mismatches == 0 && expected_sync_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
